// File: src/fio_pkg.sv
// Shared types and constants for the four-channel FIR block.
`default_nettype none

package fio_pkg;

    localparam int NUM_CH   = 4;
    localparam int SMP_W    = 16;
    localparam int FRAC_W   = 15;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef logic signed [SMP_W-1:0] smp_t;
    typedef smp_t [NUM_CH-1:0] coef_row_t;

    // Control from sequencer to the MAC datapath.
    typedef struct packed {
        logic clear;       // zero the accumulators, new sample starts
        logic data_valid;  // registered memory data is a live tap
    } mac_ctrl_t;

endpackage

`default_nettype wire

// File: src/fio_delay.sv
// Sample delay line: circular buffer memory with head pointer and fill count.
`default_nettype none

module fio_delay
    import fio_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         wr_en,
    input  smp_t                        wr_data,
    input  wire                         rd_en,
    input  wire  [$clog2(TAPS)-1:0]     rd_age,
    output smp_t                        rd_data
);

    localparam int TAP_W = $clog2(TAPS);
    localparam int CNT_W = $clog2(TAPS + 1);

    smp_t mem [TAPS];

    logic [TAP_W-1:0] head_reg;
    logic [TAP_W-1:0] head_next;
    logic [CNT_W-1:0] fill_reg;
    logic             live_reg;
    smp_t             rd_q;

    logic [TAP_W:0]   diff;
    logic [TAP_W:0]   wrap;
    logic [TAP_W-1:0] rd_addr;

    assign head_next = (head_reg == TAP_W'(TAPS - 1)) ? '0 : head_reg + 1'b1;

    // Address of the sample rd_age items older than the newest one.
    assign diff    = {1'b0, head_reg} - {1'b0, rd_age};
    assign wrap    = diff + (TAP_W + 1)'(TAPS);
    assign rd_addr = diff[TAP_W] ? wrap[TAP_W-1:0] : diff[TAP_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
            live_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                head_reg <= head_next;
                if (fill_reg < CNT_W'(TAPS))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (rd_en)
            begin
                live_reg <= CNT_W'(rd_age) < fill_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head_next] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    // Entries never written read as zero.
    assign rd_data = live_reg ? rd_q : '0;

endmodule

`default_nettype wire

// File: src/fio_coef.sv
// Coefficient store: one row of four channels per tap, row valid bits, RMW write.
`default_nettype none

module fio_coef
    import fio_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         rd_en,
    input  wire  [$clog2(TAPS)-1:0]     rd_addr,
    input  wire                         wr_en,
    input  wire  [$clog2(TAPS)-1:0]     wr_addr,
    input  wire  [1:0]                  wr_channel,
    input  smp_t                        wr_value,
    output coef_row_t                   rd_row
);

    coef_row_t mem [TAPS];

    logic [TAPS-1:0] row_valid_reg;
    logic            valid_q;
    coef_row_t       row_q;
    coef_row_t       merged;

    assign rd_row = valid_q ? row_q : '0;

    // Write merges the new channel into the row read the cycle before.
    always_comb
    begin
        merged             = rd_row;
        merged[wr_channel] = wr_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            valid_q       <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                valid_q <= row_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= merged;
        end
        if (rd_en)
        begin
            row_q <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/fio_mac.sv
// Four multiply-accumulate lanes with final round and saturate.
`default_nettype none

module fio_mac
    import fio_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire        clk,
    input  wire        rst_n,
    input  mac_ctrl_t  ctrl,
    input  smp_t       sample,
    input  coef_row_t  row,
    output logic       busy,
    output coef_row_t  result
);

    localparam int PROD_W = 2 * SMP_W;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);

    logic signed [PROD_W-1:0] prod_reg [NUM_CH];
    logic signed [ACC_W-1:0]  acc_reg  [NUM_CH];
    logic                     prod_valid_reg;

    logic signed [ACC_W:0] rnd [NUM_CH];
    logic signed [ACC_W:0] quo [NUM_CH];

    assign busy = prod_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctrl.data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (ctrl.data_valid)
            begin
                prod_reg[c] <= PROD_W'(sample) * PROD_W'(row[c]);
            end
            if (ctrl.clear)
            begin
                acc_reg[c] <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg[c] <= acc_reg[c] + ACC_W'(prod_reg[c]);
            end
        end
    end

    // Round half up, floor shift by 15, clamp to 16 bits.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rnd[c] = (ACC_W + 1)'(acc_reg[c]) + (ACC_W + 1)'(1 << (FRAC_W - 1));
            quo[c] = rnd[c] >>> FRAC_W;
            if (quo[c] > $signed((ACC_W + 1)'(32767)))
            begin
                result[c] = 16'sh7FFF;
            end
            else if (quo[c] < -$signed((ACC_W + 1)'(32768)))
            begin
                result[c] = 16'sh8000;
            end
            else
            begin
                result[c] = quo[c][SMP_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

// File: src/fir_one_in_four_out.sv
// Top level: one sample stream into four FIR filters sharing one delay line.
//
// A sample item (tuser = 0) enters the delay line and yields one output item
// with the four filter results; a coefficient item (tuser = 1) writes one tap
// of one channel and yields nothing. Delay samples and coefficients live in
// single-port-read synchronous memories; four 16x16 multipliers run in
// parallel, one tap per cycle, so a sample item occupies the block through
// its accept, one memory read per tap, the pipeline drain and the round
// step before the next item is taken. The tap sweep over the memory read
// port is the longest of these steps. A coefficient item takes a row read,
// then a merged write back. Coefficient taps at or beyond TAPS are dropped.
// Both stores read as zero after reset through a fill count (delay line)
// and per-tap row valid bits (coefficients); there is no clearing pass.
// Accumulation is exact; each result is rounded (add 2^14), shifted right
// 15 and saturated to signed 16 bits. The output register lets the next
// item be accepted while a result waits on m_tready.
`default_nettype none

module fir_one_in_four_out
    import fio_pkg::*;
#(
    parameter int TAPS = 64
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_tvalid,
    output logic                   s_tready,
    // sample_in[15:0], coef_channel[17:16], coef_tap[23:18], coef_value[39:24]
    input  wire  [S_DATA_W-1:0]    s_tdata,
    // kind[0]
    input  wire                    s_tuser,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    // out_a[15:0], out_b[31:16], out_c[47:32], out_d[63:48]
    output logic [M_DATA_W-1:0]    m_tdata
);

    localparam int TAP_W = $clog2(TAPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH,
        ST_CWRITE
    } state_t;

    state_t              state_reg;
    logic [TAP_W-1:0]    tap_reg;
    logic                rd_valid_reg;
    logic [TAP_W-1:0]    cw_tap_reg;
    logic [1:0]          cw_ch_reg;
    smp_t                cw_val_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Input fields
    smp_t       in_sample;
    logic [1:0] in_channel;
    logic [5:0] in_tap;
    smp_t       in_value;
    logic [31:0] tap_wide;
    logic        tap_ok;

    logic accept;
    logic accept_sample;
    logic accept_coef;
    logic sweep_issue;
    logic sweep_last;
    logic out_free;

    logic             coef_rd_en;
    logic [TAP_W-1:0] coef_rd_addr;
    smp_t             dly_data;
    coef_row_t        coef_row;
    coef_row_t        mac_result;
    logic             mac_busy;
    mac_ctrl_t        mac_ctrl;

    assign in_sample  = s_tdata[15:0];
    assign in_channel = s_tdata[17:16];
    assign in_tap     = s_tdata[23:18];
    assign in_value   = s_tdata[39:24];
    assign tap_wide   = 32'(in_tap);
    assign tap_ok     = tap_wide < TAPS;

    assign s_tready      = (state_reg == ST_IDLE);
    assign accept        = s_tvalid && s_tready;
    assign accept_sample = accept && (s_tuser == KIND_SAMPLE);
    assign accept_coef   = accept && (s_tuser == KIND_COEF) && tap_ok;
    assign sweep_issue   = (state_reg == ST_SWEEP);
    assign sweep_last    = (tap_reg == TAP_W'(TAPS - 1));
    assign out_free      = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Coefficient read port: tap sweep, or the row about to be modified.
    assign coef_rd_en   = sweep_issue || accept_coef;
    assign coef_rd_addr = sweep_issue ? tap_reg : tap_wide[TAP_W-1:0];

    assign mac_ctrl.clear      = accept_sample;
    assign mac_ctrl.data_valid = rd_valid_reg;

    fio_delay #(
        .TAPS (TAPS)
    ) u_delay (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept_sample),
        .wr_data (in_sample),
        .rd_en   (sweep_issue),
        .rd_age  (tap_reg),
        .rd_data (dly_data)
    );

    fio_coef #(
        .TAPS (TAPS)
    ) u_coef (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (coef_rd_en),
        .rd_addr    (coef_rd_addr),
        .wr_en      (state_reg == ST_CWRITE),
        .wr_addr    (cw_tap_reg),
        .wr_channel (cw_ch_reg),
        .wr_value   (cw_val_reg),
        .rd_row     (coef_row)
    );

    fio_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .sample (dly_data),
        .row    (coef_row),
        .busy   (mac_busy),
        .result (mac_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tap_reg      <= '0;
            rd_valid_reg <= 1'b0;
            cw_tap_reg   <= '0;
            cw_ch_reg    <= '0;
            cw_val_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= sweep_issue;
            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    tap_reg <= '0;
                    if (accept_sample)
                    begin
                        state_reg <= ST_SWEEP;
                    end
                    else if (accept_coef)
                    begin
                        cw_tap_reg <= tap_wide[TAP_W-1:0];
                        cw_ch_reg  <= in_channel;
                        cw_val_reg <= in_value;
                        state_reg  <= ST_CWRITE;
                    end
                end
                ST_SWEEP:
                begin
                    tap_reg <= tap_reg + 1'b1;
                    if (sweep_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_valid_reg && !mac_busy)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tdata_reg  <= mac_result;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                ST_CWRITE:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A new result only comes out of the round step.
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish step");

    // Registered memory data only follows a sweep read.
    a_read_follows_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SWEEP))
        else $error("tap data valid without a sweep read");

    // Pipeline is empty whenever a new item may enter.
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_valid_reg && !mac_busy))
        else $error("MAC pipeline busy while idle");

    // Round step is entered only after the accumulators have settled.
    a_finish_settled: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == ST_FINISH) |-> $past(!rd_valid_reg && !mac_busy))
        else $error("round started before accumulation finished");

endmodule

`default_nettype wire
